[design/triangle_box_overlap_test_defines.svh]
// Assertion macros for the triangle against box overlap test.
// Used by triangle_box_overlap_test.sv; depends on nothing else.
`ifndef TRIANGLE_BOX_OVERLAP_TEST_DEFINES_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTH
`define TBOX_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define TBOX_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define TBOX_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define TBOX_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[design/tbox_pkg.sv]
// Shared widths, register indexes and result codes of the triangle box test.
// Depends on nothing.
package tbox_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int EW = COORD_WIDTH + 1;  // coordinate difference
	localparam int AW = COORD_WIDTH + 2;  // edge axis component
	localparam int PW = AW + COORD_WIDTH; // edge axis product
	localparam int SW = PW + 2;           // sum of the x, y and z edge products
	localparam int CW = 2 * EW;           // normal cross term
	localparam int NW = CW + 1;           // normal component
	localparam int QW = NW + EW;          // normal product
	localparam int TW = QW + 2;           // sum of three normal products
	localparam int ADDR_WIDTH = 5;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	typedef enum logic [2:0] {
		DEC_INSIDE = 3'd0,
		DEC_NONE   = 3'd1,
		DEC_FACE   = 3'd2,
		DEC_NORMAL = 3'd3,
		DEC_EDGE   = 3'd4
	} dec_t;

	typedef struct packed {
		logic vert_in;
		logic face_sep;
	} early_t;
endpackage

[design/triangle_box_overlap_test.sv]
// Triangle against axis-aligned box overlap test, six-stage pipeline.
// Depends on tbox_pkg and triangle_box_overlap_test_defines.svh.
//
//  channel   signals                                     direction
//  tri       tri_valid, tri_stall, v0_x .. v2_z          in
//  res       res_valid, res_stall, overlap, decided_by   out
//  cfg       psel penable pwrite paddr pwdata prdata pready
//
// One triangle enters per cycle while tri_stall is low; its result word is offered
// from the stage 6 register. The depth is set by the normal path: differences, cross
// products, the normal, its products with the corner offsets and their sum.
// Reset clears the valid bits, the skid register and the box registers.
// A result word that meets a stall moves to a skid register; while that holds
// a word every stage freezes and the input is stalled.
`include "triangle_box_overlap_test_defines.svh"
module triangle_box_overlap_test (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tbox_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic tri_valid,
	output logic tri_stall,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v0_x,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v0_y,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v0_z,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v1_x,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v1_y,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v1_z,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v2_x,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v2_y,
	input  logic signed [tbox_pkg::COORD_WIDTH-1:0] v2_z,
	output logic res_valid,
	input  logic res_stall,
	output logic overlap,
	output logic [2:0] decided_by
);
	import tbox_pkg::*;
	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_min_q [3];
	logic signed [W-1:0] box_max_q [3];
	logic hold;
	logic skid_q;
	logic cfg_wr;
	logic [2:0] cfg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIN_X: box_min_q[0] <= pwdata[W-1:0];
				REG_MIN_Y: box_min_q[1] <= pwdata[W-1:0];
				REG_MIN_Z: box_min_q[2] <= pwdata[W-1:0];
				REG_MAX_X: box_max_q[0] <= pwdata[W-1:0];
				REG_MAX_Y: box_max_q[1] <= pwdata[W-1:0];
				REG_MAX_Z: box_max_q[2] <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	// read back, sign extended
	always_comb begin
		unique case (cfg_idx)
			REG_MIN_X: prdata = 32'(box_min_q[0]);
			REG_MIN_Y: prdata = 32'(box_min_q[1]);
			REG_MIN_Z: prdata = 32'(box_min_q[2]);
			REG_MAX_X: prdata = 32'(box_max_q[0]);
			REG_MAX_Y: prdata = 32'(box_max_q[1]);
			REG_MAX_Z: prdata = 32'(box_max_q[2]);
			default:   prdata = '0;
		endcase
	end

	// freeze the whole pipe while the skid register holds a word
	assign hold      = skid_q;
	assign tri_stall = hold;

	// stage 1: capture the triangle
	logic valid_s1;
	logic signed [W-1:0] v_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!hold) valid_s1 <= tri_valid;
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			v_s1[0][0] <= v0_x; v_s1[0][1] <= v0_y; v_s1[0][2] <= v0_z;
			v_s1[1][0] <= v1_x; v_s1[1][1] <= v1_y; v_s1[1][2] <= v1_z;
			v_s1[2][0] <= v2_x; v_s1[2][1] <= v2_y; v_s1[2][2] <= v2_z;
		end
	end

	// vertex and face tests, edges, corner offsets from v0
	early_t early_c;
	logic signed [EW-1:0] e1_c [3], e2_c [3], dmin_c [3], dmax_c [3];
	logic signed [EW-1:0] ed_c [3][3];

	always_comb begin
		logic in_v;
		logic signed [W-1:0] lo, hi;
		early_c = '0;
		for (int i = 0; i < 3; i++) begin
			in_v = 1'b1;
			for (int k = 0; k < 3; k++)
				if (v_s1[i][k] < box_min_q[k] || v_s1[i][k] > box_max_q[k]) in_v = 1'b0;
			early_c.vert_in |= in_v;
		end
		for (int k = 0; k < 3; k++) begin
			lo = v_s1[0][k];
			hi = v_s1[0][k];
			for (int i = 1; i < 3; i++) begin
				if (v_s1[i][k] < lo) lo = v_s1[i][k];
				if (v_s1[i][k] > hi) hi = v_s1[i][k];
			end
			if (hi < box_min_q[k] || lo > box_max_q[k]) early_c.face_sep = 1'b1;
			e1_c[k]   = EW'(v_s1[1][k]) - EW'(v_s1[0][k]);
			e2_c[k]   = EW'(v_s1[2][k]) - EW'(v_s1[0][k]);
			dmin_c[k] = EW'(box_min_q[k]) - EW'(v_s1[0][k]);
			dmax_c[k] = EW'(box_max_q[k]) - EW'(v_s1[0][k]);
			ed_c[0][k] = EW'(v_s1[0][k]) - EW'(v_s1[1][k]);
			ed_c[1][k] = EW'(v_s1[1][k]) - EW'(v_s1[2][k]);
			ed_c[2][k] = EW'(v_s1[2][k]) - EW'(v_s1[0][k]);
		end
	end

	// stage 2
	logic valid_s2;
	early_t early_s2;
	logic signed [W-1:0]  v_s2 [3][3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], dmin_s2 [3], dmax_s2 [3];
	logic signed [EW-1:0] ed_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (!hold) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			early_s2 <= early_c;
			v_s2 <= v_s1;
			e1_s2 <= e1_c; e2_s2 <= e2_c;
			dmin_s2 <= dmin_c; dmax_s2 <= dmax_c;
			ed_s2 <= ed_c;
		end
	end

	// normal cross terms and edge axis products
	logic signed [CW-1:0] cr_c [6];
	logic signed [PW-1:0] pbmin_c [9][3], pbmax_c [9][3];
	logic signed [PW-1:0] pv_c [9][3][3];

	always_comb begin
		logic signed [AW-1:0] ax [3];
		cr_c[0] = CW'(e1_s2[1]) * CW'(e2_s2[2]);
		cr_c[1] = CW'(e1_s2[2]) * CW'(e2_s2[1]);
		cr_c[2] = CW'(e1_s2[2]) * CW'(e2_s2[0]);
		cr_c[3] = CW'(e1_s2[0]) * CW'(e2_s2[2]);
		cr_c[4] = CW'(e1_s2[0]) * CW'(e2_s2[1]);
		cr_c[5] = CW'(e1_s2[1]) * CW'(e2_s2[0]);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				unique case (k)
					0: begin
						ax[0] = '0; ax[1] = AW'(ed_s2[i][2]); ax[2] = -AW'(ed_s2[i][1]);
					end
					1: begin
						ax[0] = -AW'(ed_s2[i][2]); ax[1] = '0; ax[2] = AW'(ed_s2[i][0]);
					end
					default: begin
						ax[0] = AW'(ed_s2[i][1]); ax[1] = -AW'(ed_s2[i][0]); ax[2] = '0;
					end
				endcase
				for (int c = 0; c < 3; c++) begin
					pbmin_c[i*3+k][c] = PW'(ax[c]) * PW'(box_min_q[c]);
					pbmax_c[i*3+k][c] = PW'(ax[c]) * PW'(box_max_q[c]);
					for (int j = 0; j < 3; j++)
						pv_c[i*3+k][j][c] = PW'(ax[c]) * PW'(v_s2[j][c]);
				end
			end
		end
	end

	// stage 3
	logic valid_s3;
	early_t early_s3;
	logic signed [EW-1:0] dmin_s3 [3], dmax_s3 [3];
	logic signed [CW-1:0] cr_s3 [6];
	logic signed [PW-1:0] pbmin_s3 [9][3], pbmax_s3 [9][3];
	logic signed [PW-1:0] pv_s3 [9][3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (!hold) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			early_s3 <= early_s2;
			dmin_s3 <= dmin_s2; dmax_s3 <= dmax_s2;
			cr_s3 <= cr_c;
			pbmin_s3 <= pbmin_c; pbmax_s3 <= pbmax_c;
			pv_s3 <= pv_c;
		end
	end

	// normal, box projection range and vertex projections per edge axis
	logic signed [NW-1:0] nrm_c [3];
	logic signed [SW-1:0] bl_c [9], bh_c [9];
	logic signed [SW-1:0] tv_c [9][3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			nrm_c[k] = NW'(cr_s3[2*k]) - NW'(cr_s3[2*k+1]);
		for (int a = 0; a < 9; a++) begin
			bl_c[a] = '0;
			bh_c[a] = '0;
			for (int c = 0; c < 3; c++) begin
				if (pbmin_s3[a][c] < pbmax_s3[a][c]) begin
					bl_c[a] = bl_c[a] + SW'(pbmin_s3[a][c]);
					bh_c[a] = bh_c[a] + SW'(pbmax_s3[a][c]);
				end else begin
					bl_c[a] = bl_c[a] + SW'(pbmax_s3[a][c]);
					bh_c[a] = bh_c[a] + SW'(pbmin_s3[a][c]);
				end
			end
			for (int j = 0; j < 3; j++)
				tv_c[a][j] = SW'(pv_s3[a][j][0]) + SW'(pv_s3[a][j][1]) + SW'(pv_s3[a][j][2]);
		end
	end

	// stage 4
	logic valid_s4;
	early_t early_s4;
	logic signed [EW-1:0] dmin_s4 [3], dmax_s4 [3];
	logic signed [NW-1:0] nrm_s4 [3];
	logic signed [SW-1:0] bl_s4 [9], bh_s4 [9];
	logic signed [SW-1:0] tv_s4 [9][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (!hold) valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			early_s4 <= early_s3;
			dmin_s4 <= dmin_s3; dmax_s4 <= dmax_s3;
			nrm_s4 <= nrm_c;
			bl_s4 <= bl_c; bh_s4 <= bh_c;
			tv_s4 <= tv_c;
		end
	end

	// normal products with corner offsets; edge axis separation
	logic signed [QW-1:0] qmin_c [3], qmax_c [3];
	logic esep_c;

	always_comb begin
		logic signed [SW-1:0] tl, th;
		for (int k = 0; k < 3; k++) begin
			qmin_c[k] = QW'(nrm_s4[k]) * QW'(dmin_s4[k]);
			qmax_c[k] = QW'(nrm_s4[k]) * QW'(dmax_s4[k]);
		end
		esep_c = 1'b0;
		for (int a = 0; a < 9; a++) begin
			tl = tv_s4[a][0];
			th = tv_s4[a][0];
			for (int j = 1; j < 3; j++) begin
				if (tv_s4[a][j] < tl) tl = tv_s4[a][j];
				if (tv_s4[a][j] > th) th = tv_s4[a][j];
			end
			if (th < bl_s4[a] || tl > bh_s4[a]) esep_c = 1'b1;
		end
	end

	// stage 5
	logic valid_s5;
	early_t early_s5;
	logic esep_s5;
	logic signed [QW-1:0] qmin_s5 [3], qmax_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else if (!hold) valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			early_s5 <= early_s4;
			esep_s5 <= esep_c;
			qmin_s5 <= qmin_c; qmax_s5 <= qmax_c;
		end
	end

	// normal range over the corners, then pick the deciding test
	logic nsep_c;
	dec_t dec_c;

	always_comb begin
		logic signed [TW-1:0] nlo, nhi;
		nlo = '0;
		nhi = '0;
		for (int k = 0; k < 3; k++) begin
			if (qmin_s5[k] < qmax_s5[k]) begin
				nlo = nlo + TW'(qmin_s5[k]);
				nhi = nhi + TW'(qmax_s5[k]);
			end else begin
				nlo = nlo + TW'(qmax_s5[k]);
				nhi = nhi + TW'(qmin_s5[k]);
			end
		end
		nsep_c = (nlo > 0) || (nhi < 0);
		priority if (early_s5.vert_in) dec_c = DEC_INSIDE;
		else if (early_s5.face_sep) dec_c = DEC_FACE;
		else if (nsep_c) dec_c = DEC_NORMAL;
		else if (esep_s5) dec_c = DEC_EDGE;
		else dec_c = DEC_NONE;
	end

	// stage 6: result word
	logic valid_s6;
	dec_t dec_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else if (!hold) valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		if (!hold) dec_s6 <= dec_c;
	end

	// skid register: take the stalled word so the pipe stall comes from a flop
	dec_t skid_dec_q;
	dec_t dec_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_q <= 1'b0;
		else if (skid_q) skid_q <= res_stall;
		else skid_q <= valid_s6 & res_stall;
	end

	always_ff @(posedge clk) begin
		if (!skid_q) skid_dec_q <= dec_s6;
	end

	assign dec_out    = skid_q ? skid_dec_q : dec_s6;
	assign res_valid  = skid_q | valid_s6;
	assign decided_by = dec_out;
	assign overlap    = (dec_out == DEC_INSIDE) || (dec_out == DEC_NONE);

	// checks
	`TBOX_ASSERT_IMPL(a_code_range, clk, arst_n, res_valid, decided_by <= DEC_EDGE)
	`TBOX_ASSERT_NEXT(a_hold_freezes, clk, arst_n, hold, $stable(valid_s3) && $stable(valid_s5))
	`TBOX_ASSERT_IMPL(a_inside_wins, clk, arst_n, valid_s5 && early_s5.vert_in, dec_c == DEC_INSIDE)
endmodule
